[hdl/sol_pkg.sv]
// Package for the self-organising list table: field widths, operation and
// policy codes, transaction structs and the stored entry type.
// No dependencies.
package sol_pkg;

  localparam int KEY_BITS      = 32;
  localparam int DATA_BITS     = 32;
  localparam int CNT_BITS      = 5;   // width of the probes and length fields
  localparam int CAPACITY_DEF  = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] POL_NONE      = 2'd0;
  localparam logic [1:0] POL_TRANSPOSE = 2'd1;
  localparam logic [1:0] POL_FRONT     = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] payload;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic [DATA_BITS-1:0] data_out;
    logic [CNT_BITS-1:0]  probes;
    logic [CNT_BITS-1:0]  length;
    logic                 overflow;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] payload;
  } entry_t;

endpackage

[hdl/self_organizing_list_table.sv]
// Insert writes at the new head, then loads the result register. Search/remove scan from
// the head; a remove hit then shifts the entries before it back one place, a search hit
// moves to front (shift, then head write) or transposes (swap) per policy. One transaction
// at a time; the single memory read port sets the scan and shift at one entry per cycle.
// Synchronous reset empties the table (head and count cleared, memory contents left alone)
// and sets policy to none. Ordered table in a circular buffer; uses sol_pkg.
module self_organizing_list_table #(
  parameter int CAPACITY = sol_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata,
  input  logic          req_valid,
  output logic          req_stall,
  input  sol_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sol_pkg::rsp_t rsp
);

  localparam int IDXW = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int FW   = sol_pkg::CNT_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_SWAP  = 3'd3;
  localparam logic [2:0] S_FRONT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // logical position -> physical address, relative to the head
  function automatic logic [IDXW-1:0] phys(input logic [IDXW-1:0] hd,
                                           input logic [CNTW-1:0] l);
    logic [CNTW:0] s;
    s = (CNTW+1)'(hd) + (CNTW+1)'(l);
    if (s >= (CNTW+1)'(CAPACITY)) s = s - (CNTW+1)'(CAPACITY);
    return s[IDXW-1:0];
  endfunction

  sol_pkg::entry_t mem [CAPACITY];
  sol_pkg::entry_t rd_data;
  logic [IDXW-1:0] rd_addr, wr_addr;
  logic            wr_en;
  sol_pkg::entry_t wr_data;

  logic [2:0]      state, state_next;
  logic [IDXW-1:0] head, head_next;
  logic [CNTW-1:0] count, count_next;
  logic [1:0]      policy;
  logic [IDXW-1:0] scan_i, scan_next;
  logic [IDXW-1:0] sh_j, sh_next;
  logic [IDXW-1:0] pos_r, pos_next;
  sol_pkg::entry_t hit_e, hit_next;
  sol_pkg::entry_t prev_e, prev_next;
  logic [1:0]      op_r, op_next;
  logic [sol_pkg::KEY_BITS-1:0]  key_r, key_next;
  logic            found_r, found_next;
  logic [sol_pkg::DATA_BITS-1:0] data_r, data_next;
  logic [CNTW-1:0] probes_r, probes_next;
  logic            ovf_r, ovf_next;
  logic            load_rsp;
  logic [IDXW-1:0] head_dec, head_inc;

  assign req_stall = (state != S_IDLE);
  assign head_dec  = (head == '0) ? IDXW'(CAPACITY - 1) : head - IDXW'(1);
  assign head_inc  = (head == IDXW'(CAPACITY - 1)) ? '0 : head + IDXW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    scan_next   = scan_i;
    sh_next     = sh_j;
    pos_next    = pos_r;
    hit_next    = hit_e;
    prev_next   = prev_e;
    op_next     = op_r;
    key_next    = key_r;
    found_next  = found_r;
    data_next   = data_r;
    probes_next = probes_r;
    ovf_next    = ovf_r;
    rd_addr     = head;
    wr_en       = 1'b0;
    wr_addr     = head;
    wr_data     = hit_e;
    load_rsp    = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next     = req.op;
          key_next    = req.key;
          found_next  = 1'b0;
          data_next   = '0;
          probes_next = '0;
          ovf_next    = 1'b0;
          state_next  = S_DONE;
          case (req.op)
            sol_pkg::OP_INSERT: begin
              if (count == CNTW'(CAPACITY)) begin
                ovf_next = 1'b1;
              end else begin
                head_next  = head_dec;
                wr_en      = 1'b1;
                wr_addr    = head_dec;
                wr_data    = {req.key, req.payload};
                count_next = count + CNTW'(1);
              end
            end
            sol_pkg::OP_REMOVE, sol_pkg::OP_SEARCH: begin
              if (count != '0) begin
                rd_addr    = head;
                scan_next  = '0;
                state_next = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // read of the next position is issued speculatively
        rd_addr   = phys(head, CNTW'(scan_i) + CNTW'(1));
        if (rd_data.key == key_r) begin
          found_next = 1'b1;
          data_next  = rd_data.payload;
          pos_next   = scan_i;
          hit_next   = rd_data;
          state_next = S_DONE;
          if (op_r == sol_pkg::OP_SEARCH) begin
            probes_next = CNTW'(scan_i) + CNTW'(1);
            if (scan_i != '0 && policy == sol_pkg::POL_TRANSPOSE) begin
              wr_en      = 1'b1;
              wr_addr    = phys(head, CNTW'(scan_i) - CNTW'(1));
              wr_data    = rd_data;
              state_next = S_SWAP;
            end else if (scan_i != '0 && policy == sol_pkg::POL_FRONT) begin
              rd_addr    = phys(head, CNTW'(scan_i) - CNTW'(1));
              sh_next    = scan_i - IDXW'(1);
              state_next = S_SHIFT;
            end
          end else if (scan_i != '0) begin
            rd_addr    = phys(head, CNTW'(scan_i) - CNTW'(1));
            sh_next    = scan_i - IDXW'(1);
            state_next = S_SHIFT;
          end else begin
            head_next  = head_inc;
            count_next = count - CNTW'(1);
          end
        end else if (CNTW'(scan_i) + CNTW'(1) == count) begin
          if (op_r == sol_pkg::OP_SEARCH) probes_next = count;
          state_next = S_DONE;
        end else begin
          // keeps the predecessor of the next position for a transpose
          prev_next = rd_data;
          scan_next = scan_i + IDXW'(1);
        end
      end
      S_SHIFT: begin
        // front part moves back one place, highest first
        wr_en   = 1'b1;
        wr_addr = phys(head, CNTW'(sh_j) + CNTW'(1));
        wr_data = rd_data;
        if (sh_j == '0) begin
          if (op_r == sol_pkg::OP_REMOVE) begin
            head_next  = head_inc;
            count_next = count - CNTW'(1);
            state_next = S_DONE;
          end else begin
            state_next = S_FRONT;
          end
        end else begin
          rd_addr = phys(head, CNTW'(sh_j) - CNTW'(1));
          sh_next = sh_j - IDXW'(1);
        end
      end
      S_SWAP: begin
        wr_en      = 1'b1;
        wr_addr    = phys(head, CNTW'(pos_r));
        wr_data    = prev_e;
        state_next = S_DONE;
      end
      S_FRONT: begin
        wr_en      = 1'b1;
        wr_addr    = head;
        wr_data    = hit_e;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      policy    <= sol_pkg::POL_NONE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (cfg_we) policy <= cfg_wdata;
      if (load_rsp) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    scan_i   <= scan_next;
    sh_j     <= sh_next;
    pos_r    <= pos_next;
    hit_e    <= hit_next;
    prev_e   <= prev_next;
    op_r     <= op_next;
    key_r    <= key_next;
    found_r  <= found_next;
    data_r   <= data_next;
    probes_r <= probes_next;
    ovf_r    <= ovf_next;
    if (load_rsp) begin
      rsp.found    <= found_r;
      rsp.data_out <= data_r;
      rsp.probes   <= FW'(probes_r);
      rsp.length   <= FW'(count);
      rsp.overflow <= ovf_r;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_scan_in_table: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> CNTW'(scan_i) < count)
    else $error("scan past last entry");

  a_shift_below_match: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> sh_j < pos_r && found_r)
    else $error("shift index not below matched position");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && rsp_valid && rsp_stall |=> state == S_DONE && $stable(rsp))
    else $error("result overwritten while previous one waits");

endmodule

[verif/tb_self_organizing_list_table.sv]
// Testbench for self_organizing_list_table: directed and random insert, remove and
// search traffic under every reorder policy, checked against an in-bench predictor.
// Depends on sol_pkg and the RTL top level only.
module tb_self_organizing_list_table;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] POL_UNUSED = 2'd3;
  localparam int         REPORT_MAX = 10;
  localparam int         CNT_W      = sol_pkg::CNT_BITS;
  localparam int         DRAIN_WAIT = 2 * sol_pkg::CAPACITY_DEF + 8;

  // Predicts the ordered table and holds the responses still owed by the block.
  class list_order_scoreboard;
    sol_pkg::entry_t entries[$];   // index 0 is the front of the list
    sol_pkg::rsp_t   owed_q[$];
    logic [1:0]      policy;
    int unsigned     mismatches;

    function new();
      policy     = sol_pkg::POL_NONE;
      mismatches = 0;
    endfunction

    function void set_policy(logic [1:0] p);
      policy = p;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function int unsigned fill();
      return entries.size();
    endfunction

    function logic [sol_pkg::KEY_BITS-1:0] key_at(int unsigned idx);
      return entries[idx].key;
    endfunction

    function void log_fault(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%s", msg);
    endfunction

    // Called once per accepted request transaction.
    function void note_request(sol_pkg::req_t r);
      sol_pkg::rsp_t   e;
      sol_pkg::entry_t moved;
      int              pos;
      e     = '0;
      pos   = -1;
      moved = '0;
      for (int i = 0; i < entries.size(); i++) begin
        if (pos < 0 && entries[i].key == r.key) pos = i;
      end
      case (r.op)
        sol_pkg::OP_INSERT: begin
          if (entries.size() >= sol_pkg::CAPACITY_DEF) begin
            e.overflow = 1'b1;
          end else begin
            moved.key     = r.key;
            moved.payload = r.payload;
            entries.push_front(moved);
          end
        end
        sol_pkg::OP_REMOVE: begin
          if (pos >= 0) begin
            e.found    = 1'b1;
            e.data_out = entries[pos].payload;
            entries.delete(pos);
          end
        end
        sol_pkg::OP_SEARCH: begin
          if (pos >= 0) begin
            e.found    = 1'b1;
            e.data_out = entries[pos].payload;
            e.probes   = CNT_W'(pos + 1);
            if (policy == sol_pkg::POL_TRANSPOSE && pos > 0) begin
              moved            = entries[pos];
              entries[pos]     = entries[pos - 1];
              entries[pos - 1] = moved;
            end else if (policy == sol_pkg::POL_FRONT && pos > 0) begin
              moved = entries[pos];
              entries.delete(pos);
              entries.push_front(moved);
            end
          end else begin
            e.probes = CNT_W'(entries.size());
          end
        end
        default: ;  // unused code: no change, zeros apart from length
      endcase
      e.length = CNT_W'(entries.size());
      owed_q.push_back(e);
    endfunction

    function void check_response(sol_pkg::rsp_t got);
      sol_pkg::rsp_t e;
      if (owed_q.size() == 0) begin
        log_fault($sformatf("unexpected response: found %0b data %h probes %0d length %0d ovf %0b",
                            got.found, got.data_out, got.probes, got.length, got.overflow));
        return;
      end
      e = owed_q.pop_front();
      if (got.found !== e.found || got.data_out !== e.data_out || got.probes !== e.probes ||
          got.length !== e.length || got.overflow !== e.overflow) begin
        log_fault($sformatf({"response mismatch (exp/got): found %0b/%0b data %h/%h ",
                             "probes %0d/%0d length %0d/%0d ovf %0b/%0b"},
                            e.found, got.found, e.data_out, got.data_out, e.probes, got.probes,
                            e.length, got.length, e.overflow, got.overflow));
      end
    endfunction

    function void close_out();
      if (owed_q.size() != 0)
        log_fault($sformatf("%0d responses never arrived", owed_q.size()));
    endfunction
  endclass

  logic          clk;
  logic          rst       = 1'b1;
  logic          cfg_we    = 1'b0;
  logic [1:0]    cfg_wdata = sol_pkg::POL_NONE;
  logic          req_valid = 1'b0;
  logic          req_stall;
  sol_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  sol_pkg::rsp_t rsp;

  list_order_scoreboard sb = new();
  bit  quiet      = 1'b0;   // no idling on either side in the closing phase
  int  burst_left = 0;
  bit  stall_now  = 1'b0;

  self_organizing_list_table #(.CAPACITY(sol_pkg::CAPACITY_DEF)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Response side: check accepted transactions and stall in random bursts.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
    if (burst_left == 0) begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        stall_now  = 1'b1;
        burst_left = $urandom_range(1, 19);
      end else begin
        stall_now  = 1'b0;
        burst_left = $urandom_range(1, 40);
      end
    end
    burst_left--;
    rsp_stall <= stall_now && !quiet;
  end

  task automatic send_op(input logic [1:0] op, input logic [sol_pkg::KEY_BITS-1:0] key,
                         input logic [sol_pkg::DATA_BITS-1:0] payload);
    sol_pkg::req_t r;
    r.op      = op;
    r.key     = key;
    r.payload = payload;
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  task automatic pause(input int cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_policy(input logic [1:0] p);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    sb.set_policy(p);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [1:0] pol, input int n_items);
    int                           ins_bias;
    int                           roll;
    logic [1:0]                   op;
    logic [sol_pkg::KEY_BITS-1:0] key;
    ins_bias = 50;
    drain();
    write_policy(pol);
    for (int i = 0; i < n_items; i++) begin
      // swing the fill level between near-empty and full
      if (i % 32 == 0) begin
        case ($urandom_range(0, 3))
          0: ins_bias = 15;
          1: ins_bias = 35;
          2: ins_bias = 55;
          default: ins_bias = 85;
        endcase
      end
      if (!quiet && $urandom_range(0, 5) == 0) pause($urandom_range(1, 19));
      roll = $urandom_range(0, 99);
      if (roll < 2) op = OP_UNUSED;
      else if (roll < ins_bias) op = sol_pkg::OP_INSERT;
      else if (roll % 3 == 0) op = sol_pkg::OP_REMOVE;
      else op = sol_pkg::OP_SEARCH;
      // small key pool gives duplicates; lookups mostly target stored keys
      roll = $urandom_range(0, 9);
      if (roll < ((op == sol_pkg::OP_INSERT) ? 2 : 7) && sb.fill() > 0)
        key = sb.key_at($urandom_range(0, sb.fill() - 1));
      else if (roll < 8)
        key = $urandom_range(0, 23);
      else
        key = $urandom;
      send_op(op, key, $urandom);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_policy(sol_pkg::POL_FRONT);

    // empty table, unused code, extremes and a duplicate key
    send_op(sol_pkg::OP_SEARCH, 32'h0, 32'h0);
    send_op(sol_pkg::OP_REMOVE, 32'h0, 32'h0);
    send_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(sol_pkg::OP_INSERT, 32'h0, 32'h0);
    send_op(sol_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(sol_pkg::OP_INSERT, 32'h0, 32'h5A5A_5A5A);
    send_op(sol_pkg::OP_SEARCH, 32'h0, 32'h0);             // front match, order kept
    send_op(sol_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'h0);     // moves to front
    send_op(sol_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0);     // head removal
    for (int i = 0; i < 14; i++)
      send_op(sol_pkg::OP_INSERT, 32'hC000_0000 | i,
              (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555);
    send_op(sol_pkg::OP_INSERT, 32'h1234_5678, 32'hDEAD_BEEF);  // full: dropped
    send_op(sol_pkg::OP_SEARCH, 32'h1234_5678, 32'h0);          // miss on a full table
    send_op(sol_pkg::OP_SEARCH, 32'h0, 32'h0);                  // deep hit, moves to front

    run_phase(sol_pkg::POL_TRANSPOSE, 145);
    run_phase(sol_pkg::POL_NONE, 145);
    run_phase(POL_UNUSED, 145);
    run_phase(sol_pkg::POL_FRONT, 145);
    run_phase(sol_pkg::POL_TRANSPOSE, 145);
    drain();
    quiet = 1'b1;
    run_phase(sol_pkg::POL_FRONT, 145);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    sb.close_out();
    if (sb.mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
hdl/sol_pkg.sv
hdl/self_organizing_list_table.sv
verif/tb_self_organizing_list_table.sv
